@@ hw/rtl/assert_macros.svh @@
// Assertion macros for checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define CHK_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ hw/rtl/sha512_pkg.sv @@
// Shared types, constants and round functions of the SHA-512 engine.
package sha512_pkg;
    localparam int LENGTH_COUNTER_BITS = 64;
    localparam int LCB = (LENGTH_COUNTER_BITS > 128) ? 128 : LENGTH_COUNTER_BITS;
    localparam int QDEPTH = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } item_t;

    localparam logic [63:0] IV [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

    localparam logic [63:0] RK [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction
endpackage

@@ hw/rtl/sha512_front.sv @@
// Input stage: accepts words, drops idle ones, queues the rest for the core.
module sha512_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,
    input  logic [1:0]         s_tuser,
    output logic               q_valid,
    input  logic               q_ready,
    output sha512_pkg::item_t  q_item
);
    localparam int AW = $clog2(sha512_pkg::QDEPTH);
    sha512_pkg::item_t mem [sha512_pkg::QDEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic push, pop, useful;

    assign s_tready = (cnt_reg != (AW+1)'(sha512_pkg::QDEPTH));
    assign useful   = s_tuser[0] | s_tuser[1];
    assign push     = s_tvalid & s_tready & useful;
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_valid & q_ready;
    assign q_item   = mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wp_reg] <= '{data_byte: s_tdata, has_byte: s_tuser[0],
                             end_of_message: s_tuser[1]};
        end
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

@@ hw/rtl/sha512_core.sv @@
// Core: packs bytes, pads, runs rounds one per cycle, emits the digest.
module sha512_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_ready,
    input  sha512_pkg::item_t  q_item,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [63:0]        m_tdata,
    output logic [3:0]         m_tuser
);
    localparam logic [2:0] ST_IN = 3'd0, ST_PAD = 3'd1, ST_RND = 3'd2,
                           ST_FIN = 3'd3, ST_OUT = 3'd4;
    logic [2:0]  st_reg;
    logic [63:0] h_reg [8];
    logic [63:0] v_reg [8];
    logic [63:0] w_reg [16];
    logic [6:0]  pos_reg;
    logic [6:0]  rnd_reg;
    logic [sha512_pkg::LCB-1:0] len_reg;
    logic        fin_reg;   // current block is the last of the message
    logic        eom_reg;   // end seen, padding still to place
    logic        pad_reg;   // padding under way, may spill into a second block
    logic [2:0]  oi_reg;

    logic [63:0] wt, w15, w2, s0, s1, ch, mj, t1, t2, wnew;
    logic [127:0] len128;
    logic [7:0]  pbyte;
    logic        pstep;

    assign len128 = 128'(len_reg);
    assign q_ready = (st_reg == ST_IN);
    assign m_tvalid = (st_reg == ST_OUT);
    assign m_tdata = h_reg[oi_reg];
    assign m_tuser = {oi_reg == 3'd7, oi_reg};

    always_comb begin
        w15 = w_reg[1]; w2 = w_reg[14];
        wnew = (sha512_pkg::rotr(w2, 19) ^ sha512_pkg::rotr(w2, 61) ^ (w2 >> 6))
             + w_reg[9]
             + (sha512_pkg::rotr(w15, 1) ^ sha512_pkg::rotr(w15, 8) ^ (w15 >> 7))
             + w_reg[0];
        wt = w_reg[0];
        s1 = sha512_pkg::rotr(v_reg[4], 14) ^ sha512_pkg::rotr(v_reg[4], 18)
           ^ sha512_pkg::rotr(v_reg[4], 41);
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + s1 + ch + sha512_pkg::RK[rnd_reg] + wt;
        s0 = sha512_pkg::rotr(v_reg[0], 28) ^ sha512_pkg::rotr(v_reg[0], 34)
           ^ sha512_pkg::rotr(v_reg[0], 39);
        mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2 = s0 + mj;
        // padding byte source: 0x80 first, zeros, then length bytes at 112..127
        if (eom_reg) pbyte = 8'h80;
        else if (fin_reg && pos_reg >= 7'd112)
            pbyte = len128[{~pos_reg[3:0], 3'b000} +: 8];
        else pbyte = 8'h00;
        pstep = 1'b0;
        if (st_reg == ST_IN && q_valid && q_item.has_byte) pstep = 1'b1;
        if (st_reg == ST_PAD) pstep = 1'b1;
    end

    always_ff @(posedge aclk) begin
        logic [7:0] b;
        logic [3:0] wi;
        logic [5:0] sh;
        b  = (st_reg == ST_PAD) ? pbyte : q_item.data_byte;
        wi = pos_reg[6:3];
        sh = 6'd56 - {pos_reg[2:0], 3'b000};
        if (pstep) begin
            if (pos_reg[2:0] == 3'd0) w_reg[wi] <= 64'(b) << sh;
            else w_reg[wi] <= w_reg[wi] | (64'(b) << sh);
        end
        if (st_reg == ST_RND) begin
            // schedule kept as a shift line: w_reg[0] is W[t], W[t+16] enters at 15
            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wnew;
            v_reg[7] <= v_reg[6]; v_reg[6] <= v_reg[5]; v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2]; v_reg[2] <= v_reg[1]; v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        if (pstep && pos_reg == 7'd127)
            for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
        if (!aresetn) begin
            st_reg <= ST_IN; pos_reg <= '0; rnd_reg <= '0; len_reg <= '0;
            fin_reg <= 1'b0; eom_reg <= 1'b0; pad_reg <= 1'b0; oi_reg <= '0;
            for (int i = 0; i < 8; i++) h_reg[i] <= sha512_pkg::IV[i];
        end else begin
            if (pstep) pos_reg <= pos_reg + 7'd1;
            case (st_reg)
                ST_IN: if (q_valid) begin
                    if (q_item.has_byte)
                        len_reg <= len_reg + {{(sha512_pkg::LCB-4){1'b0}}, 4'd8};
                    if (q_item.end_of_message) begin
                        eom_reg <= 1'b1;
                        fin_reg <= 1'b0;
                        if (q_item.has_byte && pos_reg == 7'd127) st_reg <= ST_RND;
                        else st_reg <= ST_PAD;
                    end else if (q_item.has_byte && pos_reg == 7'd127) begin
                        st_reg <= ST_RND;
                    end
                end
                ST_PAD: begin
                    eom_reg <= 1'b0;
                    pad_reg <= 1'b1;
                    if (pos_reg == 7'd111 && !eom_reg) fin_reg <= 1'b1;
                    if (pos_reg == 7'd111 && eom_reg) fin_reg <= 1'b1;
                    if (pos_reg == 7'd127) st_reg <= ST_RND;
                end
                ST_RND: begin
                    rnd_reg <= rnd_reg + 7'd1;
                    if (rnd_reg == 7'd79) begin
                        rnd_reg <= '0;
                        st_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
                    if (fin_reg) st_reg <= ST_OUT;
                    else if (eom_reg || pad_reg) st_reg <= ST_PAD;
                    else st_reg <= ST_IN;
                end
                ST_OUT: if (m_tready) begin
                    oi_reg <= oi_reg + 3'd1;
                    if (oi_reg == 3'd7) begin
                        st_reg <= ST_IN; fin_reg <= 1'b0; len_reg <= '0;
                        pad_reg <= 1'b0;
                        pos_reg <= '0;
                        for (int i = 0; i < 8; i++) h_reg[i] <= sha512_pkg::IV[i];
                    end
                end
                default: st_reg <= ST_IN;
            endcase
        end
    end
endmodule

@@ hw/rtl/sha512_hash_engine.sv @@
// SHA-512 engine top level: input queue feeding the compression core.
// Bytes are taken one per cycle while the input queue has room; each full block
// then runs its rounds and a chaining step in the core; the 4-word queue absorbs.
// End of message: padding runs one byte per cycle (up to 2 blocks), then the
// eight digest words leave one per cycle as the sink accepts them.
// Reset (aresetn low, synchronous) empties the queue and loads the IVs.
module sha512_hash_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic [1:0]  s_tuser,   // [0] has_byte, [1] end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // digest_word
    output logic [3:0]  m_tuser    // [2:0] word_index, [3] last_word
);
    logic              q_valid, q_ready;
    sha512_pkg::item_t q_item;

    // front end: idle words are dropped, useful ones queued
    sha512_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .q_valid, .q_ready, .q_item);

    // back end: packing, padding, rounds and digest output
    sha512_core u_core (
        .aclk, .aresetn, .q_valid, .q_ready, .q_item,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser);
endmodule

@@ hw/rtl/sha512_checker.sv @@
// Port-level checker for the SHA-512 engine, bound to the top level.
`include "assert_macros.svh"
module sha512_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [3:0]  m_tuser
);
    `CHK_IMPL(a_last, aclk, aresetn, m_tvalid, m_tuser[3] == (m_tuser[2:0] == 3'd7), "last flag")
    `CHK_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "hold")
    `CHK_NEXT(a_idx, aclk, aresetn, m_tvalid && m_tready && !m_tuser[3], m_tvalid && m_tuser[2:0] == $past(m_tuser[2:0]) + 3'd1, "index step")
endmodule

bind sha512_hash_engine sha512_checker u_chk (
    .aclk, .aresetn, .m_tvalid, .m_tready, .m_tdata, .m_tuser);
